/* rtl/framed_zero_crossing_rate_core_defines.svh */
// Assertion macros shared by the checker of the framed zero-crossing rate core.
`ifndef FRAMED_ZERO_CROSSING_RATE_CORE_DEFINES_SVH
`define FRAMED_ZERO_CROSSING_RATE_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define FZCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define FZCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define FZCR_ASSERT_AFTER(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fzcr_pkg.sv */
// Types and constants of the framed zero-crossing rate core.
package fzcr_pkg;

    localparam int MAX_FRAME   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int FLAG_AW     = $clog2(MAX_FRAME);
    localparam int FILL_W      = $clog2(MAX_FRAME + 1);

    localparam int WIDTH_W     = 11;
    localparam int HOP_W       = 16;
    localparam int SCALE_W     = 32;
    localparam int SCALE_FRAC  = 16;
    localparam int COUNT_W     = 10;
    localparam int RATE_W      = 26;
    localparam int PROD_W      = COUNT_W + SCALE_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int OUT_DEPTH   = 4;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OCC_W       = OUT_AW + 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [COUNT_W-1:0]            t_count;
    typedef logic [RATE_W-1:0]             t_rate;
    typedef logic [CFG_INDEX_W-1:0]        t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]         t_cfg_data;

    localparam t_cfg_index CFG_FRAME_WIDTH = CFG_INDEX_W'(0);
    localparam t_cfg_index CFG_HOP         = CFG_INDEX_W'(1);
    localparam t_cfg_index CFG_RATE_SCALE  = CFG_INDEX_W'(2);

    localparam logic [WIDTH_W-1:0] FRAME_WIDTH_RESET = WIDTH_W'(32);
    localparam logic [HOP_W-1:0]   HOP_RESET         = HOP_W'(16);
    localparam logic [SCALE_W-1:0] RATE_SCALE_RESET  = SCALE_W'(2048000);
    localparam int                 MIN_FRAME         = 2;

endpackage

/* rtl/framed_zero_crossing_rate_core.sv */
// Top level of the framed zero-crossing rate core.
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  -------------------------------
//  sample    in         i_valid / o_stall          i_sample
//  result    out        o_valid / i_stall          o_crossing_count, o_rate_hz
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One sample beat is taken every cycle while o_stall is low. The sample that closes a
// frame passes the stage after the synchronous read of the flag RAM, the stage that
// feeds the multiplier that scales the count into Hz, and the result queue.
// Reset is synchronous and active low. It needs no clearing pass over the flag RAM:
// a flag is only counted once the fill counter shows that it was written since the
// last reset or frame width write.
// A four-entry result queue absorbs stalls on the result side. The sample side is
// stalled only when the queue together with the results still in flight could fill it.
module framed_zero_crossing_rate_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fzcr_pkg::t_sample   i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output fzcr_pkg::t_count    o_crossing_count,
    output fzcr_pkg::t_rate     o_rate_hz,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  fzcr_pkg::t_cfg_index i_cfg_index,
    input  fzcr_pkg::t_cfg_data i_cfg_data
);
    import fzcr_pkg::*;

    // Configuration registers.
    logic [WIDTH_W-1:0] r_frame_width;
    logic [HOP_W-1:0]   r_hop;
    logic [SCALE_W-1:0] r_rate_scale;

    // Framing state.
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [FLAG_AW-1:0]     r_wp;
    logic [FILL_W-1:0]      r_fill;
    logic [HOP_W-1:0]       r_hop_cd;
    logic [COUNT_W-1:0]     r_rc;

    // One flag per adjacent sample pair, kept as a ring.
    logic                   r_flag_ram [MAX_FRAME];
    logic                   r_rd_flag;

    // Stage after the RAM read.
    logic                   r_s1_valid;
    logic                   r_s1_flag;
    logic                   r_s1_live;
    logic                   r_s1_emit;

    // Stage that feeds the multiplier.
    logic                   r_s2_valid;
    logic [COUNT_W-1:0]     r_s2_count;

    // Result queue.
    logic [COUNT_W-1:0]     r_q_count [OUT_DEPTH];
    logic [RATE_W-1:0]      r_q_rate  [OUT_DEPTH];
    logic [OUT_AW-1:0]      r_q_wr;
    logic [OUT_AW-1:0]      r_q_rd;
    logic [OUT_AW:0]        r_q_cnt;

    logic                   accept;
    logic                   cfg_we;
    logic                   frame_we;
    logic                   pop;
    logic                   push;
    logic [FILL_W-1:0]      eff_width;
    logic [FILL_W-1:0]      span;
    logic [HOP_W-1:0]       eff_hop;
    logic [FLAG_AW-1:0]     drop;
    logic                   cur_flag;
    logic                   n_emit;
    logic [FILL_W-1:0]      n_fill;
    logic [HOP_W-1:0]       n_hop_cd;
    logic [HOP_W-1:0]       cd_dec;
    logic [FLAG_AW-1:0]     n_wp;
    logic [COUNT_W-1:0]     n_rc;
    logic [PROD_W-1:0]      product;
    logic [OCC_W-1:0]       occupancy;

    // The queue plus every result still in the pipeline must leave room for one more.
    assign occupancy = OCC_W'(r_q_cnt) + OCC_W'(r_s1_valid & r_s1_emit) + OCC_W'(r_s2_valid);
    assign o_stall   = (occupancy >= OCC_W'(OUT_DEPTH));
    assign accept    = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign frame_we    = cfg_we && (i_cfg_index == CFG_FRAME_WIDTH);

    // Frame width is clamped into the range the ring supports; a hop of zero acts as one.
    always_comb begin
        if (32'(r_frame_width) > 32'(MAX_FRAME)) begin
            eff_width = FILL_W'(MAX_FRAME);
        end else if (32'(r_frame_width) < 32'(MIN_FRAME)) begin
            eff_width = FILL_W'(MIN_FRAME);
        end else begin
            eff_width = FILL_W'(r_frame_width);
        end
        span    = eff_width - FILL_W'(1);
        eff_hop = (r_hop == '0) ? HOP_W'(1) : r_hop;
    end

    // The flag that leaves the frame was written span samples ago.
    always_comb begin
        if (FILL_W'(r_wp) >= span) begin
            drop = FLAG_AW'(FILL_W'(r_wp) - span);
        end else begin
            drop = FLAG_AW'(FILL_W'(r_wp) + FILL_W'(MAX_FRAME) - span);
        end
        n_wp = (r_wp == FLAG_AW'(MAX_FRAME - 1)) ? '0 : r_wp + FLAG_AW'(1);
    end

    // A pair counts only when both samples are nonzero and their signs differ.
    assign cur_flag = (i_sample != '0) && (r_prev != '0) &&
                      (i_sample[SAMPLE_BITS-1] != r_prev[SAMPLE_BITS-1]);

    // Frame fill and hop countdown decide whether this sample closes a frame.
    always_comb begin
        n_fill   = r_fill;
        n_hop_cd = r_hop_cd;
        n_emit   = 1'b0;
        cd_dec   = (r_hop_cd != '0) ? r_hop_cd - HOP_W'(1) : r_hop_cd;
        if (r_fill < eff_width) begin
            n_fill = r_fill + FILL_W'(1);
            if (n_fill == eff_width) begin
                n_emit   = 1'b1;
                n_hop_cd = eff_hop;
            end
        end else if (cd_dec == '0) begin
            n_emit   = 1'b1;
            n_hop_cd = eff_hop;
        end else begin
            n_hop_cd = cd_dec;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RESET;
            r_hop         <= HOP_RESET;
            r_rate_scale  <= RATE_SCALE_RESET;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_HOP:         r_hop         <= i_cfg_data[HOP_W-1:0];
                CFG_RATE_SCALE:  r_rate_scale  <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Flag RAM: write the new pair at the write pointer, read the pair leaving the frame.
    // The two addresses always differ because the span lies between one and the depth minus one.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flag_ram[r_wp] <= cur_flag;
            r_rd_flag        <= r_flag_ram[drop];
        end
    end

    // Framing state is updated as each sample beat is taken; a frame width write restarts it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_hop_cd <= '0;
        end else if (frame_we) begin
            r_wp     <= '0;
            r_fill   <= '0;
            r_hop_cd <= '0;
        end else if (accept) begin
            r_prev   <= i_sample;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_hop_cd <= n_hop_cd;
        end
    end

    // The outgoing flag is live only if it was written since framing restarted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_flag <= cur_flag;
        r_s1_live <= (r_fill >= span);
        r_s1_emit <= n_emit;
    end

    // Running count: add the incoming flag, subtract the one that left the frame.
    assign n_rc = r_rc + COUNT_W'(r_s1_flag) - COUNT_W'(r_s1_live & r_rd_flag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc       <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            if (frame_we) begin
                r_rc <= '0;
            end else if (r_s1_valid) begin
                r_rc <= n_rc;
            end
        end
        r_s2_count <= n_rc;
    end

    // Scale the count to Hz; the Q16.16 fraction is dropped.
    assign product = PROD_W'(r_s2_count) * PROD_W'(r_rate_scale);
    assign push    = r_s2_valid;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_count[r_q_wr] <= r_s2_count;
            r_q_rate[r_q_wr]  <= product[SCALE_FRAC+RATE_W-1:SCALE_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= '0;
            r_q_rd  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (push) begin
                r_q_wr <= r_q_wr + OUT_AW'(1);
            end
            if (pop) begin
                r_q_rd <= r_q_rd + OUT_AW'(1);
            end
            r_q_cnt <= r_q_cnt + (OUT_AW+1)'(push) - (OUT_AW+1)'(pop);
        end
    end

    assign o_valid          = (r_q_cnt != '0);
    assign o_crossing_count = r_q_count[r_q_rd];
    assign o_rate_hz        = r_q_rate[r_q_rd];

endmodule

/* rtl/fzcr_checker.sv */
// Port-level checker of the framed zero-crossing rate core and its bind.
`include "framed_zero_crossing_rate_core_defines.svh"

module fzcr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input fzcr_pkg::t_count o_crossing_count,
    input fzcr_pkg::t_rate  o_rate_hz
);

    `FZCR_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result beat dropped while stalled")
    `FZCR_ASSERT_NEXT(a_payload_held, i_clk, i_rst_n, o_valid && i_stall, $stable(o_crossing_count) && $stable(o_rate_hz), "result payload changed while stalled")
    `FZCR_ASSERT_SAME(a_zero_rate, i_clk, i_rst_n, o_valid && (o_crossing_count == '0), o_rate_hz == '0, "nonzero rate for a frame without crossings")
    `FZCR_ASSERT_AFTER(a_reset_empty, i_clk, !i_rst_n, !o_valid, "result beat right after reset")

endmodule

bind framed_zero_crossing_rate_core fzcr_checker u_fzcr_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the framed zero-crossing rate core.
`timescale 1ns / 100ps

module testbench;
    import fzcr_pkg::*;

    // The clock period is 10 ns, and reset is held at the start only.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 8;

    // The package names the three registers; this index decodes to none of them.
    localparam t_cfg_index CFG_UNUSED = CFG_INDEX_W'(3);

    localparam t_sample MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample MOST_POSITIVE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // These are the shapes of sample stream that the random phases draw from.
    typedef enum {SHAPE_NOISE, SHAPE_ALTERNATE, SHAPE_RUNS, SHAPE_NEAR_ZERO} t_sample_shape;

    typedef struct packed {
        t_count count;
        t_rate  rate;
    } t_crossing_result;

    // DUT connections. Every input has a known value from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    t_sample    i_sample    = '0;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    t_count     o_crossing_count;
    t_rate      o_rate_hz;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = CFG_FRAME_WIDTH;
    t_cfg_data  i_cfg_data  = '0;

    // This is the local copy of the register file as the DUT should hold it.
    logic [WIDTH_W-1:0] cfg_frame_width;
    logic [HOP_W-1:0]   cfg_hop;
    logic [SCALE_W-1:0] cfg_rate_scale;

    // This is the predictor state: a flag ring of sign changes and the counters that frame it.
    logic [MAX_FRAME-1:0] zc_flags;
    t_sample              zc_prev;
    int unsigned          zc_running;
    int unsigned          zc_wp;
    int unsigned          zc_fill;
    int unsigned          zc_hop_left;

    // These are the crossing results predicted but not yet seen on the result channel.
    t_crossing_result crossing_forecast[$];

    // Idling odds shared by both sides: zero turns idling off, larger values make it rarer.
    int unsigned gap_odds = 0;
    int unsigned stall_left = 0;

    t_sample     last_drawn = '0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned samples_sent = 0;
    int unsigned registers_written = 0;
    int unsigned cycle_count = 0;

    framed_zero_crossing_rate_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_crossing_count (o_crossing_count),
        .o_rate_hz        (o_rate_hz),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The watchdog catches a hung handshake or results that never drain.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Frame width values below the minimum or above the ring size are clamped.
    function automatic int unsigned active_width();
        if (cfg_frame_width < MIN_FRAME) return MIN_FRAME;
        if (cfg_frame_width > MAX_FRAME) return MAX_FRAME;
        return cfg_frame_width;
    endfunction

    // A frame width write restarts framing. The previous sample survives it.
    function automatic void clear_framing();
        zc_flags    = '0;
        zc_running  = 0;
        zc_wp       = 0;
        zc_fill     = 0;
        zc_hop_left = 0;
    endfunction

    // This runs once per accepted sample beat. It updates the flag ring and the running count,
    // and it queues a crossing result when a frame closes: first after a full frame, then on
    // every hop.
    function automatic void predict_crossing_rate(input t_sample s);
        int unsigned      w;
        int unsigned      span;
        int unsigned      drop;
        int unsigned      reload;
        logic             crossing;
        logic             emit;
        logic [63:0]      product;
        t_crossing_result r;

        w      = active_width();
        span   = w - 1;
        reload = (cfg_hop == 0) ? 1 : cfg_hop;

        // A pair counts only when both samples are nonzero and their signs differ.
        crossing = (s != 0) && (zc_prev != 0) &&
                   (s[SAMPLE_BITS-1] != zc_prev[SAMPLE_BITS-1]);

        // The flag that leaves the frame sits span entries behind the write pointer.
        drop = (zc_wp >= span) ? zc_wp - span : zc_wp + MAX_FRAME - span;
        if (drop >= MAX_FRAME) drop = 0;
        zc_running      = zc_running + crossing - zc_flags[drop];
        zc_flags[zc_wp] = crossing;
        zc_wp           = (zc_wp + 1 >= MAX_FRAME) ? 0 : zc_wp + 1;
        zc_prev         = s;

        emit = 1'b0;
        if (zc_fill < w) begin
            zc_fill++;
            if (zc_fill == w) begin
                emit        = 1'b1;
                zc_hop_left = reload;
            end
        end else begin
            if (zc_hop_left > 0) zc_hop_left--;
            if (zc_hop_left == 0) begin
                emit        = 1'b1;
                zc_hop_left = reload;
            end
        end

        if (emit) begin
            r.count = t_count'(zc_running);
            product = 64'(r.count) * 64'(cfg_rate_scale);
            r.rate  = t_rate'(product >> SCALE_FRAC);
            crossing_forecast.push_back(r);
        end
    endfunction

    // The monitor checks each result beat against the oldest prediction. The same process
    // drives the stall bursts on the result side.
    always @(posedge i_clk) begin : result_monitor
        t_crossing_result due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (crossing_forecast.size() == 0) begin
                $display("%0t: unexpected result beat, count %0d rate %0d",
                         $time, o_crossing_count, o_rate_hz);
                mismatches++;
            end else begin
                due = crossing_forecast.pop_front();
                results_checked++;
                if (o_crossing_count !== due.count) begin
                    $display("%0t: crossing_count expected %0d actual %0d",
                             $time, due.count, o_crossing_count);
                    mismatches++;
                end
                if (o_rate_hz !== due.rate) begin
                    $display("%0t: rate_hz expected %0d actual %0d",
                             $time, due.rate, o_rate_hz);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            stall_left = $urandom_range(1, 9);
        end
        i_stall <= (stall_left > 0);
    end

    // This sends one sample beat and waits for it to be taken. It may idle first for a
    // random burst. Valid stays high between back-to-back beats.
    task automatic send_sample(input t_sample s);
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
        predict_crossing_rate(s);
    endtask

    // This stops the sample stream and waits until every predicted result has come. It then
    // lets the pipeline settle, since a sample that closes no frame may still be in flight.
    task automatic drain_results();
        int unsigned waited;
        i_valid <= 1'b0;
        waited = 0;
        while (crossing_forecast.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (crossing_forecast.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, crossing_forecast.size());
            mismatches += crossing_forecast.size();
            crossing_forecast.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only while the core is idle. The local register copy is
    // updated once the beat is taken.
    task automatic write_register(input t_cfg_index idx, input t_cfg_data data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        registers_written++;
        case (idx)
            CFG_FRAME_WIDTH: begin
                cfg_frame_width = data[WIDTH_W-1:0];
                clear_framing();
            end
            CFG_HOP:        cfg_hop = data[HOP_W-1:0];
            CFG_RATE_SCALE: cfg_rate_scale = data;
            default: ;
        endcase
    endtask

    // This draws the next sample in the given shape. Zeros and the most negative value are
    // mixed in now and then.
    function automatic t_sample draw_sample(input t_sample_shape shape);
        logic    negative;
        t_sample mag;
        t_sample value;
        negative = last_drawn[SAMPLE_BITS-1];
        if (shape == SHAPE_ALTERNATE || (shape == SHAPE_RUNS && $urandom_range(0, 3) == 0))
            negative = !negative;
        mag = t_sample'($urandom_range(1, MOST_POSITIVE));
        case (shape)
            SHAPE_NOISE:     value = t_sample'($urandom);
            SHAPE_NEAR_ZERO: value = t_sample'(int'($urandom_range(0, 4)) - 2);
            default: begin
                if ($urandom_range(0, 15) == 0)
                    value = '0;
                else if (negative)
                    value = ($urandom_range(0, 31) == 0) ? MOST_NEGATIVE : -mag;
                else
                    value = mag;
            end
        endcase
        last_drawn = value;
        return value;
    endfunction

    // The register defaults from reset are used as they are. The first sample is paired
    // with the cleared previous sample, so it cannot count as a crossing.
    task automatic test_reset_settings();
        gap_odds = 8;
        send_sample(MOST_NEGATIVE);
        repeat (69) send_sample(draw_sample(SHAPE_RUNS));
    endtask

    // With a two-sample frame and a hop of one, every beat after the first closes a frame of exactly one pair.
    // This walks the sign boundaries and the zero cases.
    task automatic test_sample_extremes();
        t_sample corners[12];
        corners = '{MOST_POSITIVE, MOST_NEGATIVE, '0, MOST_NEGATIVE, t_sample'(-1),
                    t_sample'(1), '0, '0, t_sample'(1), t_sample'(-1), MOST_POSITIVE,
                    MOST_NEGATIVE};
        write_register(CFG_HOP, t_cfg_data'(1));
        write_register(CFG_FRAME_WIDTH, t_cfg_data'(2));
        foreach (corners[k]) send_sample(corners[k]);
    endtask

    // Frame widths below the minimum, a hop of zero, an undecoded index, a zero scale, and a
    // hop longer than the frame.
    task automatic test_config_corners();
        write_register(CFG_FRAME_WIDTH, {21'($urandom_range(1, 2097151)), 11'd0});
        repeat (3) send_sample(draw_sample(SHAPE_ALTERNATE));
        write_register(CFG_FRAME_WIDTH, t_cfg_data'(1));
        write_register(CFG_HOP, {16'hFFFF, 16'd0});
        repeat (4) send_sample(draw_sample(SHAPE_ALTERNATE));
        write_register(CFG_UNUSED, t_cfg_data'($urandom));
        write_register(CFG_RATE_SCALE, '0);
        repeat (3) send_sample(draw_sample(SHAPE_NOISE));
        write_register(CFG_FRAME_WIDTH, t_cfg_data'(3));
        write_register(CFG_HOP, t_cfg_data'(6));
        write_register(CFG_RATE_SCALE, t_cfg_data'(RATE_SCALE_RESET));
        repeat (10) send_sample(draw_sample(SHAPE_ALTERNATE));
    endtask

    // An oversized width clamps to the full ring. A strictly alternating stream with no zeros
    // drives the count to its top value, and the largest scale pushes the rate to its top bits.
    task automatic test_widest_frame();
        t_sample mag;
        write_register(CFG_FRAME_WIDTH, t_cfg_data'(2047));
        write_register(CFG_HOP, t_cfg_data'(1));
        write_register(CFG_RATE_SCALE, '1);
        gap_odds = 4;
        for (int unsigned k = 0; k < MAX_FRAME + 2; k++) begin
            mag = t_sample'($urandom_range(1, MOST_POSITIVE));
            send_sample(k[0] ? -mag : mag);
        end
    endtask

    // Each random phase picks new settings and then streams samples. Some phases touch only
    // hop or only the scale, so a countdown already running carries across the write.
    task automatic test_random_framing(input int unsigned target);
        int unsigned   sent;
        int unsigned   width;
        int unsigned   hop_value;
        int unsigned   w;
        int unsigned   n;
        t_cfg_data     data;
        t_sample_shape shape;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 24))
                    0, 1:    width = $urandom_range(0, 1);
                    2:       width = $urandom_range(49, 64);
                    default: width = $urandom_range(2, 48);
                endcase
                data = $urandom;
                data[WIDTH_W-1:0] = width[WIDTH_W-1:0];
                write_register(CFG_FRAME_WIDTH, data);
            end
            w = active_width();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       hop_value = 0;
                    1:       hop_value = $urandom_range(0, 1) ? 65535 : $urandom_range(1000, 65534);
                    2, 3:    hop_value = w + $urandom_range(1, 20);
                    default: hop_value = $urandom_range(1, w);
                endcase
                data = $urandom;
                data[HOP_W-1:0] = hop_value[HOP_W-1:0];
                write_register(CFG_HOP, data);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       write_register(CFG_RATE_SCALE, '0);
                    1:       write_register(CFG_RATE_SCALE, '1);
                    2:       write_register(CFG_RATE_SCALE, t_cfg_data'(RATE_SCALE_RESET));
                    default: write_register(CFG_RATE_SCALE, t_cfg_data'($urandom));
                endcase
            end
            case ($urandom_range(0, 3))
                0:       gap_odds = 0;
                1:       gap_odds = 2;
                default: gap_odds = 8;
            endcase
            shape = t_sample_shape'($urandom_range(0, 3));
            n = ((w > 64) ? 8 : w) + $urandom_range(8, 80);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0)
                    send_sample(draw_sample(SHAPE_NOISE));
                else
                    send_sample(draw_sample(shape));
            end
            sent += n;
        end
    endtask

    // The closing stretch runs with no idling on either side, so beats arrive back to back.
    task automatic test_steady_stream();
        write_register(CFG_FRAME_WIDTH, t_cfg_data'(16));
        write_register(CFG_HOP, t_cfg_data'(4));
        gap_odds = 0;
        repeat (100) send_sample(draw_sample(SHAPE_RUNS));
    endtask

    initial begin
        cfg_frame_width = FRAME_WIDTH_RESET;
        cfg_hop         = HOP_RESET;
        cfg_rate_scale  = RATE_SCALE_RESET;
        zc_prev         = '0;
        clear_framing();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_sample_extremes();
        test_config_corners();
        test_widest_frame();
        test_random_framing(200);
        test_steady_stream();
        drain_results();

        $display("Sent %0d sample beats and checked %0d result beats around %0d register writes.",
                 samples_sent, results_checked, registers_written);
        $display("Widths went from below the minimum to past the ring size, with hops of zero, one and longer than the frame.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* framed_zero_crossing_rate_core.f */
+incdir+rtl
rtl/fzcr_pkg.sv
rtl/framed_zero_crossing_rate_core.sv
rtl/fzcr_checker.sv
tb/testbench.sv
